FILE: hw/rtl/pts_pkg.sv
// Shared types, codes and defaults of the priority thread scheduler.
`timescale 1ns / 1ps

package pts_pkg;

    localparam int DEF_THREAD_SLOTS = 16;
    localparam int DEF_WAIT_QUEUES  = 16;
    localparam logic [7:0] MAIN_PRIO_RESET = 8'd16;
    localparam int IDLE_SLOT = 1;

    typedef enum logic [1:0] {
        ST_SLEEPING = 2'd0,
        ST_READY    = 2'd1,
        ST_RUNNING  = 2'd2
    } t_state;

    typedef enum logic [2:0] {
        ACT_CREATE = 3'd0,
        ACT_WAKEUP = 3'd1,
        ACT_SLEEP  = 3'd2,
        ACT_QWAIT  = 3'd3,
        ACT_WAKEQ  = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        OP_CREATE,
        OP_WAKEUP,
        OP_SLEEP,
        OP_QWAIT,
        OP_WAKEQ,
        OP_CFG
    } t_op;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CFG,
        CMD_DECODE,
        CMD_UL_HEAD,
        CMD_UL_WALK,
        CMD_UL_CLR,
        CMD_SET_PRI,
        CMD_REMOVE_SLEEP,
        CMD_REMOVE_WAIT,
        CMD_REMOVE_MAIN,
        CMD_INS_LOAD,
        CMD_INS_LOAD_KEEP,
        CMD_INS_SCAN,
        CMD_WQ_STEP,
        CMD_RESCHED
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CFG_CHK,
        S_DECODE,
        S_UL_HEAD,
        S_UL_WALK,
        S_UL_CLR,
        S_SET_PRI,
        S_REMOVE,
        S_INS_LOAD,
        S_INS_SCAN,
        S_WQ_STEP,
        S_RESCHED,
        S_FIN
    } t_fsm;

    typedef struct packed {
        t_cmd cmd;
        logic fin;
    } t_ctrl;

    typedef struct packed {
        logic [2:0] act;
        logic       dec_ign;
        logic       st0_sleep;
        logic       ul_none;
        logic       ul_hit;
        logic       walk_done;
        logic       ins_full;
        logic       ins_hit;
        logic       wq_end;
        logic       out_free;
    } t_status;

endpackage

FILE: hw/rtl/pts_ctrl.sv
// Sequencer of the priority thread scheduler: at most one datapath command per cycle.
`timescale 1ns / 1ps

module pts_ctrl import pts_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_cfg_we,
    input  t_status i_status,
    output t_ctrl   o_ctrl,
    output logic    o_ready
);

    t_fsm r_state, n_state;
    t_op  r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_CREATE;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        o_ctrl.cmd  = CMD_NONE;
        o_ctrl.fin  = 1'b0;
        o_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = !i_cfg_we;
                if (i_cfg_we) begin
                    o_ctrl.cmd = CMD_CFG;
                    n_op       = OP_CFG;
                    n_state    = S_CFG_CHK;
                end else if (i_valid) begin
                    o_ctrl.cmd = CMD_LOAD;
                    n_state    = S_DECODE;
                end
            end
            S_CFG_CHK: begin
                if (i_status.st0_sleep) begin
                    n_state = S_IDLE;
                end else begin
                    o_ctrl.cmd = CMD_REMOVE_MAIN;
                    n_state    = S_INS_LOAD;
                end
            end
            S_DECODE: begin
                o_ctrl.cmd = CMD_DECODE;
                unique case (i_status.act)
                    ACT_CREATE: n_op = OP_CREATE;
                    ACT_WAKEUP: n_op = OP_WAKEUP;
                    ACT_SLEEP:  n_op = OP_SLEEP;
                    ACT_QWAIT:  n_op = OP_QWAIT;
                    default:    n_op = OP_WAKEQ;
                endcase
                if (i_status.dec_ign) begin
                    n_state = S_RESCHED;
                end else begin
                    unique case (i_status.act)
                        ACT_CREATE, ACT_WAKEUP: n_state = S_UL_HEAD;
                        ACT_SLEEP, ACT_QWAIT:   n_state = S_REMOVE;
                        default:                n_state = S_WQ_STEP;
                    endcase
                end
            end
            S_UL_HEAD: begin
                o_ctrl.cmd = CMD_UL_HEAD;
                if (i_status.ul_none) begin
                    n_state = (r_op == OP_CREATE) ? S_SET_PRI : S_INS_LOAD;
                end else if (i_status.ul_hit) begin
                    n_state = S_UL_CLR;
                end else begin
                    n_state = S_UL_WALK;
                end
            end
            S_UL_WALK: begin
                o_ctrl.cmd = CMD_UL_WALK;
                if (i_status.walk_done) begin
                    n_state = S_UL_CLR;
                end
            end
            S_UL_CLR: begin
                o_ctrl.cmd = CMD_UL_CLR;
                n_state    = (r_op == OP_CREATE) ? S_SET_PRI : S_INS_LOAD;
            end
            S_SET_PRI: begin
                o_ctrl.cmd = CMD_SET_PRI;
                n_state    = S_RESCHED;
            end
            S_REMOVE: begin
                o_ctrl.cmd = (r_op == OP_QWAIT) ? CMD_REMOVE_WAIT : CMD_REMOVE_SLEEP;
                n_state    = S_RESCHED;
            end
            S_INS_LOAD: begin
                o_ctrl.cmd = (r_op == OP_CFG) ? CMD_INS_LOAD_KEEP : CMD_INS_LOAD;
                if (!i_status.ins_full) begin
                    n_state = S_INS_SCAN;
                end else if (r_op == OP_WAKEQ) begin
                    n_state = S_WQ_STEP;
                end else if (r_op == OP_CFG) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RESCHED;
                end
            end
            S_INS_SCAN: begin
                o_ctrl.cmd = CMD_INS_SCAN;
                if (i_status.ins_hit) begin
                    if (r_op == OP_WAKEQ) begin
                        n_state = S_WQ_STEP;
                    end else if (r_op == OP_CFG) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_RESCHED;
                    end
                end
            end
            S_WQ_STEP: begin
                o_ctrl.cmd = CMD_WQ_STEP;
                n_state    = i_status.wq_end ? S_RESCHED : S_INS_LOAD;
            end
            S_RESCHED: begin
                o_ctrl.cmd = CMD_RESCHED;
                n_state    = S_FIN;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_ctrl.fin = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: hw/rtl/pts_dp.sv
// Datapath of the priority thread scheduler: slot tables, ready list, wait queues.
`timescale 1ns / 1ps

module pts_dp import pts_pkg::*; #(
    parameter int THREAD_SLOTS = DEF_THREAD_SLOTS,
    parameter int WAIT_QUEUES  = DEF_WAIT_QUEUES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl      i_ctrl,
    input  logic [2:0] i_action,
    input  logic [3:0] i_thread_id,
    input  logic       i_use_current,
    input  logic [7:0] i_priority_req,
    input  logic [3:0] i_queue_id,
    input  logic       i_in_interrupt,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_ready,
    output t_status    o_status,
    output logic       o_valid,
    output logic       o_switched,
    output logic [3:0] o_previous_thread,
    output logic [3:0] o_running_thread,
    output logic       o_ignored
);

    localparam int SIW = $clog2(THREAD_SLOTS);
    localparam int PW  = $clog2(THREAD_SLOTS + 1);
    localparam int CW  = PW;
    localparam int QIW = (WAIT_QUEUES > 1) ? $clog2(WAIT_QUEUES) : 1;
    localparam int QPW = $clog2(WAIT_QUEUES + 1);
    localparam logic [PW-1:0]  NO_SLOT  = PW'(THREAD_SLOTS);
    localparam logic [QPW-1:0] NO_QUEUE = QPW'(WAIT_QUEUES);

    t_state           r_st  [THREAD_SLOTS];
    logic [7:0]       r_pr  [THREAD_SLOTS];
    logic [SIW-1:0]   r_ro  [THREAD_SLOTS];
    logic [PW-1:0]    r_qn  [THREAD_SLOTS];
    logic [QPW-1:0]   r_sq  [THREAD_SLOTS];
    logic [PW-1:0]    r_qh  [WAIT_QUEUES];
    logic [CW-1:0]    r_rc;
    logic [SIW-1:0]   r_cur;

    logic [2:0]       r_act;
    logic [3:0]       r_tid;
    logic             r_uc;
    logic [7:0]       r_prio;
    logic [3:0]       r_qid;
    logic             r_irq;
    logic [SIW-1:0]   r_prev;
    logic [SIW-1:0]   r_s;
    logic [QIW-1:0]   r_q;
    logic             r_ign;
    logic             r_sw;
    logic [SIW-1:0]   r_islot;
    logic [7:0]       r_ipri;
    logic [CW-1:0]    r_i;
    logic [PW-1:0]    r_p;
    logic [PW-1:0]    r_snext;
    logic [CW-1:0]    r_guard;
    logic [PW-1:0]    r_t;
    logic             r_ovalid;

    logic [7:0]       s8;
    logic [7:0]       q8;
    logic [SIW-1:0]   sidx;
    logic [QIW-1:0]   qidx;
    t_state           st_s;
    logic             dec_ign;
    logic [QPW-1:0]   sq_s;
    logic [QIW-1:0]   ul_q;
    logic [SIW-1:0]   pidx;
    logic [SIW-1:0]   tidx;
    logic [SIW-1:0]   ro_i;
    logic             walk_end;
    logic [THREAD_SLOTS-1:0] rm_match;
    logic [THREAD_SLOTS-1:0] rm_shift;

    // Event decode on the held beat
    always_comb begin
        s8   = ((r_act == ACT_SLEEP || r_act == ACT_QWAIT) && r_uc) ? 8'(r_cur) : 8'(r_tid);
        q8   = 8'(r_qid);
        sidx = s8[SIW-1:0];
        qidx = q8[QIW-1:0];
        st_s = r_st[sidx];
        dec_ign = 1'b0;
        if (r_act > ACT_WAKEQ) begin
            dec_ign = 1'b1;
        end else if (r_act <= ACT_QWAIT && s8 >= 8'(THREAD_SLOTS)) begin
            dec_ign = 1'b1;
        end else if ((r_act == ACT_QWAIT || r_act == ACT_WAKEQ) && q8 >= 8'(WAIT_QUEUES)) begin
            dec_ign = 1'b1;
        end else if (r_act == ACT_CREATE || r_act == ACT_WAKEUP) begin
            dec_ign = (st_s != ST_SLEEPING);
        end else if (r_act == ACT_SLEEP || r_act == ACT_QWAIT) begin
            dec_ign = (s8 == 8'(IDLE_SLOT)) || (st_s == ST_SLEEPING);
        end
    end

    always_comb begin
        sq_s     = r_sq[r_s];
        ul_q     = sq_s[QIW-1:0];
        pidx     = r_p[SIW-1:0];
        tidx     = r_t[SIW-1:0];
        ro_i     = r_ro[r_i[SIW-1:0]];
        walk_end = (r_p >= NO_SLOT) || (r_guard == CW'(THREAD_SLOTS));
        o_status.act       = r_act;
        o_status.dec_ign   = dec_ign;
        o_status.st0_sleep = (r_st[0] == ST_SLEEPING);
        o_status.ul_none   = (sq_s >= NO_QUEUE);
        o_status.ul_hit    = (r_qh[ul_q] == PW'(r_s));
        o_status.walk_done = walk_end || (r_qn[pidx] == PW'(r_s));
        o_status.ins_full  = (r_rc == CW'(THREAD_SLOTS));
        o_status.ins_hit   = (r_i == r_rc) || (r_pr[ro_i] <= r_ipri);
        o_status.wq_end    = (r_t >= NO_SLOT) || (r_guard == CW'(THREAD_SLOTS));
        o_status.out_free  = !r_ovalid || i_ready;
    end

    // Removal from the ready list: entries after the match close up
    always_comb begin
        logic acc;
        acc = 1'b0;
        for (int j = 0; j < THREAD_SLOTS; j++) begin
            rm_match[j] = (CW'(j) < r_rc) && (r_ro[j] == r_islot);
            acc         = acc | rm_match[j];
            rm_shift[j] = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < THREAD_SLOTS; j++) begin
                r_st[j] <= ST_SLEEPING;
                r_pr[j] <= 8'd0;
                r_ro[j] <= '0;
                r_qn[j] <= NO_SLOT;
                r_sq[j] <= NO_QUEUE;
            end
            for (int k = 0; k < WAIT_QUEUES; k++) begin
                r_qh[k] <= NO_SLOT;
            end
            r_st[0]         <= ST_RUNNING;
            r_st[IDLE_SLOT] <= ST_READY;
            r_pr[0]         <= MAIN_PRIO_RESET;
            r_ro[IDLE_SLOT] <= SIW'(IDLE_SLOT);
            r_rc            <= CW'(2);
            r_cur           <= '0;
            r_ovalid        <= 1'b0;
            r_sw            <= 1'b0;
            r_ign           <= 1'b0;
        end else begin
            unique case (i_ctrl.cmd)
                CMD_NONE: begin
                end
                CMD_LOAD: begin
                    r_act  <= i_action;
                    r_tid  <= i_thread_id;
                    r_uc   <= i_use_current;
                    r_prio <= i_priority_req;
                    r_qid  <= i_queue_id;
                    r_irq  <= i_in_interrupt;
                    r_prev <= r_cur;
                end
                CMD_CFG: begin
                    r_pr[0] <= i_cfg_wdata;
                    r_islot <= '0;
                end
                CMD_DECODE: begin
                    r_ign   <= dec_ign;
                    r_sw    <= 1'b0;
                    r_s     <= sidx;
                    r_islot <= sidx;
                    r_q     <= qidx;
                    r_t     <= r_qh[qidx];
                    r_guard <= '0;
                end
                CMD_UL_HEAD: begin
                    if (sq_s < NO_QUEUE) begin
                        if (r_qh[ul_q] == PW'(r_s)) begin
                            r_qh[ul_q] <= r_qn[r_s];
                        end else begin
                            r_p     <= r_qh[ul_q];
                            r_snext <= r_qn[r_s];
                            r_guard <= '0;
                        end
                    end
                end
                CMD_UL_WALK: begin
                    if (!walk_end) begin
                        if (r_qn[pidx] == PW'(r_s)) begin
                            r_qn[pidx] <= r_snext;
                        end else begin
                            r_p     <= r_qn[pidx];
                            r_guard <= r_guard + 1'b1;
                        end
                    end
                end
                CMD_UL_CLR: begin
                    r_qn[r_s] <= NO_SLOT;
                    r_sq[r_s] <= NO_QUEUE;
                end
                CMD_SET_PRI: begin
                    r_pr[r_s] <= r_prio;
                end
                CMD_REMOVE_SLEEP, CMD_REMOVE_WAIT, CMD_REMOVE_MAIN: begin
                    for (int j = 0; j + 1 < THREAD_SLOTS; j++) begin
                        if (rm_shift[j]) begin
                            r_ro[j] <= r_ro[j + 1];
                        end
                    end
                    if (|rm_match) begin
                        r_rc <= r_rc - 1'b1;
                    end
                    if (i_ctrl.cmd != CMD_REMOVE_MAIN) begin
                        r_st[r_s] <= ST_SLEEPING;
                    end
                    if (i_ctrl.cmd == CMD_REMOVE_WAIT) begin
                        r_qn[r_s] <= r_qh[r_q];
                        r_qh[r_q] <= PW'(r_s);
                        r_sq[r_s] <= QPW'(r_q);
                    end
                end
                CMD_INS_LOAD, CMD_INS_LOAD_KEEP: begin
                    r_ipri <= r_pr[r_islot];
                    r_i    <= '0;
                    if (i_ctrl.cmd == CMD_INS_LOAD) begin
                        r_st[r_islot] <= ST_READY;
                    end
                end
                CMD_INS_SCAN: begin
                    if (o_status.ins_hit) begin
                        for (int j = 1; j < THREAD_SLOTS; j++) begin
                            if (CW'(j) > r_i) begin
                                r_ro[j] <= r_ro[j - 1];
                            end
                        end
                        r_ro[r_i[SIW-1:0]] <= r_islot;
                        r_rc <= r_rc + 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                CMD_WQ_STEP: begin
                    if (o_status.wq_end) begin
                        r_qh[r_q] <= NO_SLOT;
                    end else begin
                        r_islot    <= tidx;
                        r_t        <= r_qn[tidx];
                        r_qn[tidx] <= NO_SLOT;
                        r_sq[tidx] <= NO_QUEUE;
                        r_guard    <= r_guard + 1'b1;
                    end
                end
                CMD_RESCHED: begin
                    if (!r_irq && r_rc != '0 && r_ro[0] != r_cur) begin
                        if (r_st[r_cur] == ST_RUNNING) begin
                            r_st[r_cur] <= ST_READY;
                        end
                        r_cur <= r_ro[0];
                        r_sw  <= 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (i_ctrl.fin) begin
                if (r_st[r_cur] == ST_READY) begin
                    r_st[r_cur] <= ST_RUNNING;
                end
                r_ovalid          <= 1'b1;
                o_switched        <= r_sw;
                o_previous_thread <= 4'(r_prev);
                o_running_thread  <= 4'(r_cur);
                o_ignored         <= r_ign;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;

    // The idle slot never leaves the ready list, so the list is never empty
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rc != '0) && (r_rc <= CW'(THREAD_SLOTS)))
        else $error("ready count out of range");

    // The head of the ready list is never a sleeping slot
    a_head_awake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st[r_ro[0]] != ST_SLEEPING)
        else $error("sleeping slot at head of ready list");

    // A result appears only after the finishing step of an event
    a_out_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(i_ctrl.fin))
        else $error("result raised without a finished event");

endmodule

FILE: hw/rtl/priority_thread_scheduler.sv
// Top level of the priority thread scheduler: sequencer and datapath.
`timescale 1ns / 1ps

//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------------------
//  event in  | i_valid / o_ready    | i_action, i_thread_id, i_use_current,
//            |                      | i_priority_req, i_queue_id, i_in_interrupt
//  result out| o_valid / i_ready    | o_switched, o_previous_thread,
//            |                      | o_running_thread, o_ignored
//  config    | i_cfg_we             | i_cfg_wdata (main thread priority)
//
// One event beat is worked at a time by a sequencer driving one datapath step a cycle.
// An event is a decode, then for each ordered insertion a load step and a scan of the
// ready-list positions up to the insertion point, and a wait queue is walked link by link;
// the serial walk of the ready list and of the queue links sets the length of an event.
// A result waits in an output register; a stalled output holds the sequencer
// in its finishing step, and the next event beat is taken as soon as it leaves.
// Reset (synchronous, active low) loads main running, idle ready, all queues empty.
// A configuration write sets the main thread priority and, unless main sleeps, reorders it by removal and insertion.

module priority_thread_scheduler import pts_pkg::*; #(
    parameter int THREAD_SLOTS = DEF_THREAD_SLOTS,
    parameter int WAIT_QUEUES  = DEF_WAIT_QUEUES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_action,
    input  logic [3:0] i_thread_id,
    input  logic       i_use_current,
    input  logic [7:0] i_priority_req,
    input  logic [3:0] i_queue_id,
    input  logic       i_in_interrupt,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_switched,
    output logic [3:0] o_previous_thread,
    output logic [3:0] o_running_thread,
    output logic       o_ignored,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    t_ctrl   ctrl;
    t_status status;

    // Sequencer: decode the event, then walk unlink, removal, insertion, reschedule
    pts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cfg_we (i_cfg_we),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_ready  (o_ready)
    );

    // Datapath: slot tables, ready list as a row of shifting cells, wait queue links
    pts_dp #(
        .THREAD_SLOTS (THREAD_SLOTS),
        .WAIT_QUEUES  (WAIT_QUEUES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (ctrl),
        .i_action          (i_action),
        .i_thread_id       (i_thread_id),
        .i_use_current     (i_use_current),
        .i_priority_req    (i_priority_req),
        .i_queue_id        (i_queue_id),
        .i_in_interrupt    (i_in_interrupt),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_ready           (i_ready),
        .o_status          (status),
        .o_valid           (o_valid),
        .o_switched        (o_switched),
        .o_previous_thread (o_previous_thread),
        .o_running_thread  (o_running_thread),
        .o_ignored         (o_ignored)
    );

endmodule
